@@ design/ssba_pkg.sv @@
package ssba_pkg;

  localparam int unsigned DEF_MAX_BINS   = 1024;
  localparam int unsigned DEF_BAND_COUNT = 10;

  localparam int unsigned MAG_W = 16;
  localparam int unsigned AVG_W = 17;
  localparam int unsigned CFG_W = 11;

  localparam int unsigned BIN_COUNT_RST = 512;

  // 0.3 in Q0.16, the complement of the 0.7 keep weight (45875).
  localparam logic [MAG_W-1:0] TAKE_W = 16'd19661;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic first;
    logic close;
    logic fdone;
  } ssba_tag_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

@@ design/ssba_queue.sv @@
module ssba_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  import ssba_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]      slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d   = push_i ? wr_q + PTR_W'(1) : wr_q;
    rd_d   = pop_i ? rd_q + PTR_W'(1) : rd_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

@@ design/ssba_front.sv @@
module ssba_front #(
  parameter int unsigned MAX_BINS   = ssba_pkg::DEF_MAX_BINS,
  parameter int unsigned BAND_COUNT = ssba_pkg::DEF_BAND_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ssba_pkg::CFG_W-1:0]    cfg_bin_count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssba_pkg::MAG_W-1:0]    left_magnitude_i,
  input  logic [ssba_pkg::MAG_W-1:0]    right_magnitude_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ssba_pkg::ssba_tag_t           tag_o,
  output logic [$clog2(MAX_BINS)-1:0]   idx_o,
  output logic [$clog2(BAND_COUNT)-1:0] band_o,
  output logic [$clog2(MAX_BINS+1)-1:0] size_o,
  output logic [ssba_pkg::MAG_W-1:0]    left_o,
  output logic [ssba_pkg::MAG_W-1:0]    right_o
);
  import ssba_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BINS);
  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned BAND_W = $clog2(BAND_COUNT);
  localparam int unsigned NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned SH     = CNT_W + BAND_W;
  localparam int unsigned RCP_W  = CNT_W + 1;
  localparam int unsigned PRD_W  = CNT_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(((2 ** SH) + BAND_COUNT - 1) / BAND_COUNT);
  localparam int unsigned N_RST_I =
      (BIN_COUNT_RST < BAND_COUNT) ? BAND_COUNT :
      ((BIN_COUNT_RST > MAX_BINS) ? MAX_BINS : BIN_COUNT_RST);
  localparam logic [CNT_W-1:0] N_RST = CNT_W'(N_RST_I);

  function automatic logic [CNT_W-1:0] clamp_bins(input logic [CFG_W-1:0] bc);
    logic [NW-1:0] v;
    v = NW'(bc);
    if (v < NW'(BAND_COUNT)) v = NW'(BAND_COUNT);
    if (v > NW'(MAX_BINS)) v = NW'(MAX_BINS);
    return CNT_W'(v);
  endfunction

  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  quo_q, quo_d;
  logic [BAND_W-1:0] rem_q, rem_d;
  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [BAND_W-1:0] band_q, band_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [CNT_W-1:0]  n_new;
  logic [PRD_W-1:0]  prd;
  logic [CNT_W-1:0]  quo_calc;
  logic [BAND_W-1:0] rem_calc;
  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic              accept;
  logic              close;
  logic              fdone;

  // Bins per band come from a multiply by the rounded-up reciprocal of the
  // band count, which is exact over the whole range of the bin count.
  assign n_new    = clamp_bins(cfg_bin_count_i);
  assign prd      = PRD_W'(n_q) * PRD_W'(RCP);
  assign quo_calc = CNT_W'(prd >> SH);
  assign rem_calc = BAND_W'(n_q - quo_calc * CNT_W'(BAND_COUNT));

  // The last band also takes the bins left over by the division.
  assign size = (band_q == BAND_W'(BAND_COUNT - 1)) ? quo_q + CNT_W'(rem_q) : quo_q;

  assign in_stall_o = busy_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_inc    = pos_q + CNT_W'(1);
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign close      = (cnt_inc == size);
  assign fdone      = (pos_inc == n_q);

  assign push_o      = accept;
  assign tag_o.first = (cnt_q == '0);
  assign tag_o.close = close;
  assign tag_o.fdone = fdone;
  assign idx_o       = pos_q[IDX_W-1:0];
  assign band_o      = band_q;
  assign size_o      = size;
  assign left_o      = left_magnitude_i;
  assign right_o     = right_magnitude_i;

  always_comb begin
    n_d    = n_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    pos_d  = pos_q;
    band_d = band_q;
    cnt_d  = cnt_q;
    if (cfg_valid_i) begin
      n_d    = n_new;
      busy_d = 1'b1;
      pos_d  = '0;
      band_d = '0;
      cnt_d  = '0;
    end else begin
      if (busy_q) begin
        quo_d  = quo_calc;
        rem_d  = rem_calc;
        busy_d = 1'b0;
      end
      if (accept) begin
        if (fdone) begin
          pos_d  = '0;
          band_d = '0;
          cnt_d  = '0;
        end else begin
          pos_d = pos_inc;
          if (close) begin
            band_d = band_q + BAND_W'(1);
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= N_RST;
      quo_q  <= '0;
      rem_q  <= '0;
      busy_q <= 1'b1;
      pos_q  <= '0;
      band_q <= '0;
      cnt_q  <= '0;
    end else begin
      n_q    <= n_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      busy_q <= busy_d;
      pos_q  <= pos_d;
      band_q <= band_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < n_q) else $error("bin position ran past the frame");
  a_band_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, band_q} < (BAND_W + 1)'(BAND_COUNT)) else $error("band index ran past the last band");
  a_cnt_in_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q < size)) else $error("band bin count reached the band size");
  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !push_o) else $error("word taken while band size is being derived");
`endif

endmodule

@@ design/ssba_back.sv @@
module ssba_back #(
  parameter int unsigned MAX_BINS   = ssba_pkg::DEF_MAX_BINS,
  parameter int unsigned BAND_COUNT = ssba_pkg::DEF_BAND_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  ssba_pkg::ssba_tag_t           tag_i,
  input  logic [$clog2(MAX_BINS)-1:0]   idx_i,
  input  logic [$clog2(BAND_COUNT)-1:0] band_i,
  input  logic [$clog2(MAX_BINS+1)-1:0] size_i,
  input  logic [ssba_pkg::MAG_W-1:0]    left_i,
  input  logic [ssba_pkg::MAG_W-1:0]    right_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssba_pkg::MAG_W-1:0]    smooth_left_o,
  output logic [ssba_pkg::MAG_W-1:0]    smooth_right_o,
  output logic                          band_done_o,
  output logic [$clog2(BAND_COUNT)-1:0] band_number_o,
  output logic [ssba_pkg::AVG_W-1:0]    band_average_o,
  output logic                          frame_done_o
);
  import ssba_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BINS);
  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned BAND_W = $clog2(BAND_COUNT);
  localparam int unsigned SUM_W  = CNT_W + AVG_W;
  localparam int unsigned DCNT_W = $clog2(AVG_W + 1);
  localparam int unsigned PROD_W = 2 * (MAG_W + 1);
  localparam logic signed [MAG_W:0] TAKE_S = $signed({1'b0, TAKE_W});

  back_state_e state_q, state_d;

  // Work item popped from the queue.
  ssba_tag_t          wk_tag_q;
  logic [IDX_W-1:0]   wk_idx_q;
  logic [BAND_W-1:0]  wk_band_q;
  logic [CNT_W-1:0]   wk_size_q;
  logic [MAG_W-1:0]   wk_left_q;
  logic [MAG_W-1:0]   wk_right_q;

  logic [2*MAG_W-1:0] hist_mem [MAX_BINS];
  logic [2*MAG_W-1:0] rd_q;
  logic [CNT_W-1:0]   hw_q, hw_d;

  logic [MAG_W-1:0]          old_l_q, old_r_q;
  logic signed [PROD_W-1:0]  prod_l_q, prod_r_q;
  logic [MAG_W-1:0]          sl_q, sr_q;
  logic [SUM_W-1:0]          sum_q;
  logic [CNT_W-1:0]          rem_q;
  logic [AVG_W-1:0]          quo_q;
  logic [DCNT_W-1:0]         dcnt_q;

  logic                 out_valid_q, out_valid_d;
  logic [MAG_W-1:0]     out_left_q, out_right_q;
  logic                 out_done_q, out_fdone_q;
  logic [BAND_W-1:0]    out_band_q;
  logic [AVG_W-1:0]     out_avg_q;

  logic                     hit;
  logic [MAG_W-1:0]         old_l, old_r;
  logic signed [MAG_W:0]    diff_l, diff_r;
  logic signed [PROD_W-1:0] prod_l_d, prod_r_d;
  logic signed [PROD_W-1:0] acc_l, acc_r;
  logic [MAG_W-1:0]         sl, sr;
  logic [SUM_W-1:0]         sum_new;
  logic [CNT_W:0]           drem_sh;
  logic                     dge;
  logic [CNT_W-1:0]         drem_nx;

  logic mem_we;
  logic div_start;
  logic out_load;

  // Entries at or above the fill count were never written and read as zero.
  assign hit    = (CNT_W'(wk_idx_q) < hw_q);
  assign old_l  = hit ? rd_q[2*MAG_W-1:MAG_W] : '0;
  assign old_r  = hit ? rd_q[MAG_W-1:0] : '0;

  // old*0.7 + new*0.3 is rewritten as old + (new - old)*0.3, one multiply.
  assign diff_l   = $signed({1'b0, wk_left_q}) - $signed({1'b0, old_l});
  assign diff_r   = $signed({1'b0, wk_right_q}) - $signed({1'b0, old_r});
  assign prod_l_d = diff_l * TAKE_S;
  assign prod_r_d = diff_r * TAKE_S;

  assign acc_l = $signed({2'b00, old_l_q, {MAG_W{1'b0}}}) + prod_l_q;
  assign acc_r = $signed({2'b00, old_r_q, {MAG_W{1'b0}}}) + prod_r_q;
  assign sl    = acc_l[2*MAG_W-1:MAG_W];
  assign sr    = acc_r[2*MAG_W-1:MAG_W];

  assign sum_new = (wk_tag_q.first ? '0 : sum_q) + SUM_W'(sl) + SUM_W'(sr);

  // The band sum is below size * 2^17, so its upper part starts out below the
  // divisor and seventeen restoring steps give the whole quotient.
  assign drem_sh = {rem_q, quo_q[AVG_W-1]};
  assign dge     = (drem_sh >= {1'b0, wk_size_q});
  assign drem_nx = dge ? CNT_W'(drem_sh - {1'b0, wk_size_q}) : drem_sh[CNT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = BK_MULT;
      end
      BK_MULT: state_d = BK_SUM;
      BK_SUM: begin
        state_d = wk_tag_q.close ? BK_DIV : BK_OUT;
      end
      BK_DIV: begin
        if (dcnt_q == DCNT_W'(1)) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o = !q_empty_i;
      BK_SUM: begin
        mem_we    = 1'b1;
        div_start = wk_tag_q.close;
      end
      BK_OUT:  out_load = !out_valid_q || !out_stall_i;
      default: q_pop_o = 1'b0;
    endcase
  end

  always_comb begin
    hw_d = hw_q;
    if (mem_we && (CNT_W'(wk_idx_q) == hw_q)) begin
      hw_d = hw_q + CNT_W'(1);
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      wk_tag_q   <= tag_i;
      wk_idx_q   <= idx_i;
      wk_band_q  <= band_i;
      wk_size_q  <= size_i;
      wk_left_q  <= left_i;
      wk_right_q <= right_i;
    end
    if (state_q == BK_MULT) begin
      old_l_q  <= old_l;
      old_r_q  <= old_r;
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    if (mem_we) begin
      sl_q  <= sl;
      sr_q  <= sr;
      sum_q <= sum_new;
    end
    if (div_start) begin
      rem_q  <= sum_new[SUM_W-1:AVG_W];
      quo_q  <= sum_new[AVG_W-1:0];
      dcnt_q <= DCNT_W'(AVG_W);
    end else if (state_q == BK_DIV) begin
      rem_q  <= drem_nx;
      quo_q  <= {quo_q[AVG_W-2:0], dge};
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
    if (out_load) begin
      out_left_q  <= sl_q;
      out_right_q <= sr_q;
      out_done_q  <= wk_tag_q.close;
      out_band_q  <= wk_tag_q.close ? wk_band_q : '0;
      out_avg_q   <= wk_tag_q.close ? quo_q : '0;
      out_fdone_q <= wk_tag_q.fdone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wk_idx_q] <= {sl, sr};
    end
    if (q_pop_o) begin
      rd_q <= hist_mem[idx_i];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smooth_left_o  = out_left_q;
  assign smooth_right_o = out_right_q;
  assign band_done_o    = out_done_q;
  assign band_number_o  = out_band_q;
  assign band_average_o = out_avg_q;
  assign frame_done_o   = out_fdone_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= CNT_W'(MAX_BINS)) else $error("history fill count beyond the store");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < wk_size_q)) else $error("divider remainder not reduced");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT && out_valid_q && out_stall_i) |=> (state_q == BK_OUT))
    else $error("result dropped while output register was full");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == BK_IDLE && !q_empty_i)) else $error("queue popped out of turn");
`endif

endmodule

@@ design/spectrum_smoother_band_averager_unit.sv @@
// Each bin passes through the back end's read, multiply, update and output steps; a
// bin that closes a band also runs the bit-serial band divider (one quotient bit a cycle).
// The back end takes the next bin only once the last has left its output step, and
// an output stall holds it there. A 2-word queue decouples input.
// Reset: asynchronous, active low. Histories read as zero through a fill count.
// After reset and each bin_count write, input stalls for one cycle.
module spectrum_smoother_band_averager_unit #(
  parameter int unsigned MAX_BINS   = ssba_pkg::DEF_MAX_BINS,
  parameter int unsigned BAND_COUNT = ssba_pkg::DEF_BAND_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssba_pkg::CFG_W-1:0]    cfg_bin_count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssba_pkg::MAG_W-1:0]    left_magnitude_i,
  input  logic [ssba_pkg::MAG_W-1:0]    right_magnitude_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssba_pkg::MAG_W-1:0]    smooth_left_o,
  output logic [ssba_pkg::MAG_W-1:0]    smooth_right_o,
  output logic                          band_done_o,
  output logic [$clog2(BAND_COUNT)-1:0] band_number_o,
  output logic [ssba_pkg::AVG_W-1:0]    band_average_o,
  output logic                          frame_done_o
);
  import ssba_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BINS);
  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned BAND_W = $clog2(BAND_COUNT);
  localparam int unsigned TAG_W  = $bits(ssba_tag_t);
  localparam int unsigned ITEM_W = TAG_W + IDX_W + BAND_W + CNT_W + 2 * MAG_W;

  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] q_rdata;

  ssba_tag_t         f_tag, b_tag;
  logic [IDX_W-1:0]  f_idx, b_idx;
  logic [BAND_W-1:0] f_band, b_band;
  logic [CNT_W-1:0]  f_size, b_size;
  logic [MAG_W-1:0]  f_left, b_left;
  logic [MAG_W-1:0]  f_right, b_right;

  // A configuration write loads the bin count and resets the frame counters, so it is always taken.
  assign cfg_ready_o = 1'b1;

  assign q_wdata = {f_tag, f_idx, f_band, f_size, f_left, f_right};
  assign {b_tag, b_idx, b_band, b_size, b_left, b_right} = q_rdata;

  ssba_front #(
    .MAX_BINS   (MAX_BINS),
    .BAND_COUNT (BAND_COUNT)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_bin_count_i   (cfg_bin_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .left_magnitude_i  (left_magnitude_i),
    .right_magnitude_i (right_magnitude_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .tag_o             (f_tag),
    .idx_o             (f_idx),
    .band_o            (f_band),
    .size_o            (f_size),
    .left_o            (f_left),
    .right_o           (f_right)
  );

  ssba_queue #(
    .W (ITEM_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  ssba_back #(
    .MAX_BINS   (MAX_BINS),
    .BAND_COUNT (BAND_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .tag_i          (b_tag),
    .idx_i          (b_idx),
    .band_i         (b_band),
    .size_i         (b_size),
    .left_i         (b_left),
    .right_i        (b_right),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smooth_left_o  (smooth_left_o),
    .smooth_right_o (smooth_right_o),
    .band_done_o    (band_done_o),
    .band_number_o  (band_number_o),
    .band_average_o (band_average_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BANDS       = ssba_pkg::DEF_BAND_COUNT;
  localparam int unsigned HIST_DEPTH  = ssba_pkg::DEF_MAX_BINS;
  localparam int unsigned KEEP_WEIGHT = 65536 - ssba_pkg::TAKE_W;
  localparam int unsigned MAG_MAX     = 65535;
  localparam int unsigned CFG_MAX     = (1 << ssba_pkg::CFG_W) - 1;

  typedef struct {
    logic [ssba_pkg::MAG_W-1:0] left;
    logic [ssba_pkg::MAG_W-1:0] right;
  } bin_pair_t;

  typedef struct {
    logic [ssba_pkg::MAG_W-1:0] smooth_left;
    logic [ssba_pkg::MAG_W-1:0] smooth_right;
    logic                       band_done;
    logic [3:0]                 band_number;
    logic [ssba_pkg::AVG_W-1:0] band_average;
    logic                       frame_done;
  } bin_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [ssba_pkg::CFG_W-1:0] cfg_bin_count_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [ssba_pkg::MAG_W-1:0] left_magnitude_i = '0;
  logic [ssba_pkg::MAG_W-1:0] right_magnitude_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [ssba_pkg::MAG_W-1:0] smooth_left_o;
  logic [ssba_pkg::MAG_W-1:0] smooth_right_o;
  logic                       band_done_o;
  logic [3:0]                 band_number_o;
  logic [ssba_pkg::AVG_W-1:0] band_average_o;
  logic                       frame_done_o;

  spectrum_smoother_band_averager_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_bin_count_i   (cfg_bin_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .left_magnitude_i  (left_magnitude_i),
    .right_magnitude_i (right_magnitude_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .smooth_left_o     (smooth_left_o),
    .smooth_right_o    (smooth_right_o),
    .band_done_o       (band_done_o),
    .band_number_o     (band_number_o),
    .band_average_o    (band_average_o),
    .frame_done_o      (frame_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Smoother and band state, mirrored from the block.
  logic [ssba_pkg::MAG_W-1:0] left_hist  [HIST_DEPTH];
  logic [ssba_pkg::MAG_W-1:0] right_hist [HIST_DEPTH];
  int unsigned                bins_cfg;
  int unsigned                bin_pos;
  int unsigned                band_pos;
  int unsigned                band_bins;
  longint unsigned            band_acc;

  bin_pair_t bins_to_send[$];
  bin_word_t smoothed_due[$];
  int unsigned bins_queued = 0;
  int unsigned bins_taken = 0;
  int unsigned mismatches = 0;
  bit          word_taken = 1'b0;
  bit          hold_off = 1'b0;

  function automatic void clear_frame();
    bin_pos   = 0;
    band_pos  = 0;
    band_bins = 0;
    band_acc  = 0;
  endfunction

  function automatic logic [ssba_pkg::MAG_W-1:0] smooth_mag(
      logic [ssba_pkg::MAG_W-1:0] prev, logic [ssba_pkg::MAG_W-1:0] mag);
    int unsigned acc;
    acc = prev * KEEP_WEIGHT + mag * int'(ssba_pkg::TAKE_W);
    return acc[31:16];
  endfunction

  function automatic void smooth_bin(bin_pair_t b);
    int unsigned n;
    int unsigned per_band;
    int unsigned slot;
    int unsigned band_size;
    bin_word_t   w;
    n = bins_cfg;
    if (n < BANDS) n = BANDS;
    if (n > HIST_DEPTH) n = HIST_DEPTH;
    per_band = n / BANDS;
    if (bin_pos >= n || band_pos >= BANDS) clear_frame();
    slot = bin_pos % HIST_DEPTH;
    w = '{default: '0};
    w.smooth_left  = smooth_mag(left_hist[slot], b.left);
    w.smooth_right = smooth_mag(right_hist[slot], b.right);
    left_hist[slot]  = w.smooth_left;
    right_hist[slot] = w.smooth_right;
    band_acc += w.smooth_left + w.smooth_right;
    band_bins++;
    // The last band takes whatever the first nine leave over.
    band_size = (band_pos < BANDS - 1) ? per_band : n - per_band * (BANDS - 1);
    if (band_size == 0) band_size = 1;
    if (band_bins >= band_size) begin
      w.band_done    = 1'b1;
      w.band_number  = band_pos[3:0];
      w.band_average = ssba_pkg::AVG_W'(band_acc / band_size);
      band_acc  = 0;
      band_bins = 0;
      band_pos++;
    end
    bin_pos++;
    if (bin_pos >= n) begin
      w.frame_done = 1'b1;
      clear_frame();
    end
    smoothed_due = {smoothed_due, w};
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: a word is taken when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      smooth_bin('{left: left_magnitude_i, right: right_magnitude_i});
      bins_taken++;
      word_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    bin_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (smoothed_due.size() == 0) begin
        $error("output word with none expected");
        mismatches++;
      end else begin
        w = smoothed_due.pop_front();
        check_field("smooth_left", w.smooth_left, smooth_left_o);
        check_field("smooth_right", w.smooth_right, smooth_right_o);
        check_field("band_done", w.band_done, band_done_o);
        check_field("band_number", w.band_number, band_number_o);
        check_field("band_average", w.band_average, band_average_o);
        check_field("frame_done", w.frame_done, frame_done_o);
      end
    end
  end

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  logic        next_valid;
  bin_pair_t   next_bin;

  always @(negedge clk_i) begin
    next_valid = in_valid_i;
    if (word_taken) begin
      word_taken = 1'b0;
      next_valid = 1'b0;
    end
    if (!next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (bins_to_send.size() > 0) begin
        next_bin = bins_to_send.pop_front();
        left_magnitude_i  <= next_bin.left;
        right_magnitude_i <= next_bin.right;
        next_valid = 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          send_calm = $urandom_range(20, 60);
        end else begin
          send_gap = idle_len();
        end
      end
    end
    in_valid_i <= next_valid;
  end

  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;
  logic        stall_now;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_now = 1'b1;
      stall_left--;
    end else begin
      stall_now = 1'b0;
      if (stall_calm > 0) begin
        stall_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        stall_calm = $urandom_range(30, 80);
      end else begin
        stall_left = idle_len();
      end
    end
    out_stall_i <= hold_off || stall_now;
  end

  // Long receiver hold-off while bins keep coming, so the input queue fills.
  initial begin
    do @(posedge clk_i); while (bins_taken < 120);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #5ms;
    $display("[spectrum_smoother_band_averager_unit] ERROR");
    $finish;
  end

  task automatic send_pair(int unsigned l, int unsigned r);
    bin_pair_t b;
    b.left  = l[15:0];
    b.right = r[15:0];
    bins_to_send = {bins_to_send, b};
    bins_queued++;
  endtask

  function automatic int unsigned random_mag();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return MAG_MAX;
      default: return $urandom_range(0, MAG_MAX);
    endcase
  endfunction

  task automatic send_bins(int unsigned count);
    repeat (count) send_pair(random_mag(), random_mag());
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (bins_taken != bins_queued || smoothed_due.size() != 0);
  endtask

  task automatic write_bin_count(int unsigned v);
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_bin_count_i <= v[ssba_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    bins_cfg = v & CFG_MAX;
    clear_frame();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  int unsigned plan_cfg  [9] = '{11, 2047, 25, 9, 10, 99, 1025, 37, 0};
  int unsigned plan_bins [9] = '{50, 150, 80, 40, 50, 120, 40, 40, 30};

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    bins_cfg = ssba_pkg::BIN_COUNT_RST;
    clear_frame();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: field extremes and alternating bit patterns.
    send_pair(0, 0);
    send_pair(MAG_MAX, MAG_MAX);
    send_pair(MAG_MAX, 0);
    send_pair(0, MAG_MAX);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    wait_idle();

    // A zero count clamps to one bin per band; this write also cuts the frame short.
    write_bin_count(0);
    for (int i = 0; i < 12; i++) send_pair(i % 3 == 2 ? 0 : MAG_MAX, i % 2 ? MAG_MAX : 0);
    wait_idle();

    foreach (plan_cfg[i]) begin
      write_bin_count(plan_cfg[i]);
      send_bins(plan_bins[i]);
      wait_idle();
    end
    write_bin_count($urandom_range(12, 60));
    send_bins(60);
    wait_idle();
    write_bin_count($urandom_range(10, 200));
    send_bins(60);
    wait_idle();

    repeat (40) @(posedge clk_i);
    if (smoothed_due.size() != 0) begin
      $error("%0d expected words never arrived", smoothed_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[spectrum_smoother_band_averager_unit] OK");
    end else begin
      $display("[spectrum_smoother_band_averager_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ssba_pkg.sv
design/ssba_queue.sv
design/ssba_front.sv
design/ssba_back.sv
design/spectrum_smoother_band_averager_unit.sv
tb/sv/tb.sv
